>>> design/stereo_biquad_filter_defines.svh
// Assertion macros for the filter's top RTL file.
`ifndef STEREO_BIQUAD_FILTER_DEFINES_SVH
`define STEREO_BIQUAD_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BIQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/biq_pkg.sv
`default_nettype none

package biq_pkg;

  // Default widths of samples and coefficient fraction.
  localparam int SAMPLE_BITS_DEFAULT    = 24;
  localparam int COEF_FRAC_BITS_DEFAULT = 23;

  // Coefficients are Q3.F: three integer bits above the fraction.
  localparam int COEF_INT_BITS = 3;
  localparam int NUM_COEFS     = 5;
  localparam int CFG_ADDR_W    = 3;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_e;

  // Pipeline control handed from the control unit to every lane.
  typedef struct packed {
    logic load_a;  // Take a new word into the product stage.
    logic fire_b;  // Finish the word in the product stage into history.
  } lane_ctrl_t;

endpackage

`default_nettype wire

>>> design/stereo_biquad_filter.sv
// Stereo direct form I biquad, one lane per channel, shared coefficients.
// An accepted word is held in the product stage, then in the output history.
// Throughput: one stereo word per cycle unless the output stalls, held by
// the a1 feedback loop (one multiply, the five-term sum and saturation).
// Reset clears all sample history and loads b0 = 1.0 with other coefficients 0.
`default_nettype none
`include "stereo_biquad_filter_defines.svh"

module stereo_biquad_filter
  import biq_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEFAULT,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0]                 cfg_addr_i,
  input  wire logic [COEF_FRAC_BITS+COEF_INT_BITS-1:0] cfg_wdata_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]         left_in_i,
  input  wire logic signed [SAMPLE_BITS-1:0]         right_in_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]              left_out_o,
  output logic signed [SAMPLE_BITS-1:0]              right_out_o
);

  localparam int COEF_W = COEF_FRAC_BITS + COEF_INT_BITS;

  logic signed [COEF_W-1:0] coef [NUM_COEFS];
  lane_ctrl_t               ctrl;
  logic                     a_valid;

  // Coefficient registers shared by both lanes.
  biq_coef_regs #(
    .COEF_W (COEF_W)
  ) u_coef_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  // Handshake and pipeline control; both lanes follow it as one output word.
  biq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl),
    .a_valid_o   (a_valid)
  );

  // Left channel lane.
  biq_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (left_in_i),
    .coef_i   (coef),
    .y_o      (left_out_o)
  );

  // Right channel lane.
  biq_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (right_in_i),
    .coef_i   (coef),
    .y_o      (right_out_o)
  );

  // A finished word always becomes visible at the next edge.
  `BIQ_ASSERT_NEXT(a_fire_shows, clk_i, rst_ni, ctrl.fire_b, out_valid_o,
    "finished word did not reach the output")

  // A held output word must never be overwritten by the lanes.
  `BIQ_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, out_valid_o && !out_ready_i,
    !ctrl.fire_b, "lane history advanced while output was stalled")

  // Empty pipeline, ready sink: a word passes the product stage to the output.
  `BIQ_ASSERT_NEXT(a_latency, clk_i, rst_ni,
    ctrl.load_a && !a_valid && !out_valid_o ##1 out_ready_i, out_valid_o,
    "word lost in an empty pipeline")

endmodule

`default_nettype wire

>>> design/biq_coef_regs.sv
`default_nettype none

module biq_coef_regs
  import biq_pkg::*;
#(
  parameter int COEF_W = 26
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0]        cfg_addr_i,
  input  wire logic [COEF_W-1:0]            cfg_wdata_i,
  output logic signed [COEF_W-1:0]          coef_o [NUM_COEFS]
);

  // Unity gain: one in Q3.F format.
  localparam logic [COEF_W-1:0] OneCoef =
    {{(COEF_INT_BITS-1){1'b0}}, 1'b1, {(COEF_W-COEF_INT_BITS){1'b0}}};

  logic signed [COEF_W-1:0] coef_q [NUM_COEFS];

  // Coefficient registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[REG_B0] <= OneCoef;
      coef_q[REG_B1] <= '0;
      coef_q[REG_B2] <= '0;
      coef_q[REG_A1] <= '0;
      coef_q[REG_A2] <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_B0:  coef_q[REG_B0] <= cfg_wdata_i;
        REG_B1:  coef_q[REG_B1] <= cfg_wdata_i;
        REG_B2:  coef_q[REG_B2] <= cfg_wdata_i;
        REG_A1:  coef_q[REG_A1] <= cfg_wdata_i;
        REG_A2:  coef_q[REG_A2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

>>> design/biq_lane.sv
`default_nettype none

module biq_lane
  import biq_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 23
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire lane_ctrl_t                                  ctrl_i,
  input  wire logic signed [SAMPLE_BITS-1:0]               sample_i,
  input  wire logic signed [COEF_FRAC_BITS+COEF_INT_BITS-1:0] coef_i [NUM_COEFS],
  output logic signed [SAMPLE_BITS-1:0]                    y_o
);

  localparam int COEF_W = COEF_FRAC_BITS + COEF_INT_BITS;
  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  // Five products plus the rounding term need three guard bits.
  localparam int ACC_W  = PROD_W + 3;
  localparam int TOP_W  = ACC_W - COEF_FRAC_BITS - SAMPLE_BITS + 1;

  localparam logic signed [ACC_W-1:0] RoundHalf =
    {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, y1_q, y2_q;
  logic signed [SAMPLE_BITS-1:0] y_d;
  logic signed [SAMPLE_BITS-1:0] fb_old;
  logic signed [PROD_W-1:0]      p_b0_q, p_b1_q, p_b2_q, p_a2_q;
  logic signed [PROD_W-1:0]      p_b0_d, p_b1_d, p_b2_d, p_a2_d, p_a1;
  logic signed [ACC_W-1:0]       acc;
  logic        [TOP_W-1:0]       acc_top;

  // The older output: if the word ahead finishes at this edge, history
  // has not shifted yet, so the older output still sits in y1.
  assign fb_old = ctrl_i.fire_b ? y1_q : y2_q;

  // Product stage: the feedforward terms and the a2 feedback term.
  assign p_b0_d = PROD_W'(coef_i[REG_B0]) * PROD_W'(sample_i);
  assign p_b1_d = PROD_W'(coef_i[REG_B1]) * PROD_W'(x1_q);
  assign p_b2_d = PROD_W'(coef_i[REG_B2]) * PROD_W'(x2_q);
  assign p_a2_d = PROD_W'(coef_i[REG_A2]) * PROD_W'(fb_old);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_a) begin
      p_b0_q <= p_b0_d;
      p_b1_q <= p_b1_d;
      p_b2_q <= p_b2_d;
      p_a2_q <= p_a2_d;
    end
  end

  // Input history shifts as each word enters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
    end else if (ctrl_i.load_a) begin
      x2_q <= x1_q;
      x1_q <= sample_i;
    end
  end

  // Feedback loop: a1 times the latest output, sum, round half up.
  assign p_a1 = PROD_W'(coef_i[REG_A1]) * PROD_W'(y1_q);
  assign acc  = ACC_W'(p_b0_q) + ACC_W'(p_b1_q) + ACC_W'(p_b2_q)
              - ACC_W'(p_a2_q) - ACC_W'(p_a1) + RoundHalf;

  // Saturate unless all bits above the sample's sign agree with it.
  assign acc_top = acc[ACC_W-1:COEF_FRAC_BITS+SAMPLE_BITS-1];

  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      y_d = acc[COEF_FRAC_BITS+SAMPLE_BITS-1:COEF_FRAC_BITS];
    end else begin
      y_d = {acc[ACC_W-1], {(SAMPLE_BITS-1){~acc[ACC_W-1]}}};
    end
  end

  // Output history holds the saturated results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y1_q <= '0;
      y2_q <= '0;
    end else if (ctrl_i.fire_b) begin
      y2_q <= y1_q;
      y1_q <= y_d;
    end
  end

  // The newest output is the word presented downstream.
  assign y_o = y1_q;

endmodule

`default_nettype wire

>>> design/biq_ctrl.sv
`default_nettype none

module biq_ctrl
  import biq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output lane_ctrl_t ctrl_o,
  output logic       a_valid_o
);

  logic a_valid_q, a_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic a_free;

  // The output word may be replaced when empty or taken this cycle.
  assign out_free = !out_valid_q || out_ready_i;
  // The product stage may load when empty or when its word moves on.
  assign a_free   = out_free || !a_valid_q;

  assign in_ready_o    = a_free;
  assign ctrl_o.load_a = in_valid_i && a_free;
  assign ctrl_o.fire_b = a_valid_q && out_free;

  // Valid flags for the product stage and the output word.
  always_comb begin
    a_valid_d   = a_valid_q;
    out_valid_d = out_valid_q;
    if (a_free) begin
      a_valid_d = ctrl_o.load_a;
    end
    if (out_free) begin
      out_valid_d = a_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign a_valid_o   = a_valid_q;

endmodule

`default_nettype wire

>>> tb/sv/stereo_biquad_filter_checker.sv
module stereo_biquad_filter_checker
  import biq_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEFAULT,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]                   cfg_addr_i,
  input  logic [COEF_FRAC_BITS+COEF_INT_BITS-1:0] cfg_wdata_i,
  input  logic                                    in_valid_i,
  input  logic                                    in_ready_i,
  input  logic signed [SAMPLE_BITS-1:0]           left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]           right_in_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0]           left_out_i,
  input  logic signed [SAMPLE_BITS-1:0]           right_out_i,
  output int                                      pending_o,
  output int                                      errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     COEF_W = COEF_FRAC_BITS + COEF_INT_BITS;
  localparam longint OUT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_LO = -OUT_HI - 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Two past inputs and two past outputs of one channel, newest first.
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } section_hist_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_word_t;

  logic signed [COEF_W-1:0] coef_q [NUM_COEFS];
  section_hist_t            hist [2];
  stereo_word_t             expected_words [$];
  int                       mismatches = 0;

  // One direct form I output: five products, round half up, saturate.
  function automatic sample_t filter_sample(sample_t x, section_hist_t h);
    longint acc;
    acc = longint'(coef_q[REG_B0]) * longint'(x)
        + longint'(coef_q[REG_B1]) * longint'($signed(h.x1))
        + longint'(coef_q[REG_B2]) * longint'($signed(h.x2))
        - longint'(coef_q[REG_A1]) * longint'($signed(h.y1))
        - longint'(coef_q[REG_A2]) * longint'($signed(h.y2));
    acc = acc + (longint'(1) <<< (COEF_FRAC_BITS - 1));
    acc = acc >>> COEF_FRAC_BITS;
    if (acc > OUT_HI) begin
      acc = OUT_HI;
    end else if (acc < OUT_LO) begin
      acc = OUT_LO;
    end
    return sample_t'(acc);
  endfunction

  // Track coefficient writes, predict each accepted word and check each result.
  always @(posedge clk_i or negedge rst_ni) begin : track
    sample_t      xin [2];
    sample_t      yout [2];
    stereo_word_t exp_word;
    if (!rst_ni) begin
      foreach (coef_q[i]) coef_q[i] = '0;
      coef_q[REG_B0] = COEF_W'(1) << COEF_FRAC_BITS;
      hist[0] = '0;
      hist[1] = '0;
      expected_words.delete();
      pending_o <= 0;
    end else begin
      // Writes to indexes past the last coefficient leave everything as it is.
      if (cfg_we_i && cfg_addr_i <= REG_A2) begin
        coef_q[cfg_addr_i] = cfg_wdata_i;
      end

      // Compare a delivered word with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $error("filtered word with no input word awaiting it: left_out %0d, right_out %0d",
                 left_out_i, right_out_i);
        end else begin
          exp_word = expected_words.pop_front();
          if (left_out_i !== exp_word.left) begin
            mismatches++;
            $error("left_out: expected %0d, actual %0d", $signed(exp_word.left), left_out_i);
          end
          if (right_out_i !== exp_word.right) begin
            mismatches++;
            $error("right_out: expected %0d, actual %0d", $signed(exp_word.right),
                   right_out_i);
          end
        end
      end

      // Run both channels on an accepted word; the saturated output is kept as history.
      if (in_valid_i && in_ready_i) begin
        xin[0] = left_in_i;
        xin[1] = right_in_i;
        for (int ch = 0; ch < 2; ch++) begin
          yout[ch] = filter_sample(xin[ch], hist[ch]);
          hist[ch].x2 = hist[ch].x1;
          hist[ch].x1 = xin[ch];
          hist[ch].y2 = hist[ch].y1;
          hist[ch].y1 = yout[ch];
        end
        expected_words.push_back({yout[0], yout[1]});
      end

      pending_o <= expected_words.size();
      errors_o  <= mismatches;
    end
  end

endmodule

>>> tb/sv/stereo_biquad_filter_test.sv
module stereo_biquad_filter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import biq_pkg::*;

  localparam int SAMPLE_BITS    = SAMPLE_BITS_DEFAULT;
  localparam int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT;
  localparam int COEF_W         = COEF_FRAC_BITS + COEF_INT_BITS;
  localparam int UNITY          = 1 << COEF_FRAC_BITS;
  localparam int TOP_IDX        = 2 ** CFG_ADDR_W - 1;
  localparam int PHASES         = 10;
  localparam int WORDS_PER_PHASE = 155;
  localparam int DRAIN_CYCLES   = 10;
  localparam int CYCLE_LIMIT    = 200000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam coef_t   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam coef_t   COEF_ONE   = coef_t'(UNITY);
  localparam coef_t   COEF_HALF  = coef_t'(UNITY / 2);

  // Kinds of random coefficient sets.
  localparam int SET_STABLE = 0;
  localparam int SET_WILD   = 1;
  localparam int SET_GENTLE = 2;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [COEF_W-1:0]     cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sample_t               left_in = '0;
  sample_t               right_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sample_t               left_out;
  sample_t               right_out;
  int                    pending;
  int                    errors;
  bit                    calm = 1'b0;
  int                    cycle_count = 0;

  stereo_biquad_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .left_in_i   (left_in),
    .right_in_i  (right_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .left_out_o  (left_out),
    .right_out_o (right_out)
  );

  stereo_biquad_filter_checker checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .left_in_i   (left_in),
    .right_in_i  (right_in),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .left_out_i  (left_out),
    .right_out_i (right_out),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver stalls now and then, except during the calm stretch.
  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 17);
  end

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly full-range samples, with extremes and small values mixed in.
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return sample_t'(int'($urandom_range(511)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic write_coef(input logic [CFG_ADDR_W-1:0] addr, input logic [COEF_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk_i);
  endtask

  // Load all five coefficients, then hit an unmapped index, which must change nothing.
  task automatic load_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
                            input coef_t a1, input coef_t a2);
    write_coef(REG_B0, b0);
    write_coef(REG_B1, b1);
    write_coef(REG_B2, b2);
    write_coef(REG_A1, a1);
    write_coef(REG_A2, a2);
    write_coef(CFG_ADDR_W'($urandom_range(NUM_COEFS, TOP_IDX)), COEF_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_coefs(input int kind);
    int    a2_raw;
    int    a1_raw;
    coef_t b [3];
    coef_t a1;
    coef_t a2;
    if (kind == SET_STABLE) begin
      // Poles inside the unit circle: a2 in [0, 0.9), |a1| < 1 + a2.
      a2_raw = $urandom_range(0, UNITY * 9 / 10);
      a1_raw = $urandom_range(0, UNITY + a2_raw - 1);
      a2 = coef_t'(a2_raw);
      a1 = $urandom_range(1) ? coef_t'(-a1_raw) : coef_t'(a1_raw);
      foreach (b[i]) b[i] = coef_t'(int'($urandom_range(0, UNITY)) - UNITY / 2);
    end else if (kind == SET_WILD) begin
      a1 = coef_t'($urandom);
      a2 = coef_t'($urandom);
      foreach (b[i]) b[i] = coef_t'($urandom);
    end else begin
      a1 = coef_t'(int'($urandom_range(0, UNITY)) - UNITY / 2);
      a2 = coef_t'(int'($urandom_range(0, UNITY)) - UNITY / 2);
      foreach (b[i]) b[i] = coef_t'(int'($urandom_range(0, UNITY)) - UNITY / 2);
    end
    load_coefs(b[0], b[1], b[2], a1, a2);
  endtask

  // Offer one word, idling before it at random, and wait until it is taken.
  task automatic send_word(input sample_t l, input sample_t r);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Stop sending and wait until every predicted word has been delivered.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients pass samples straight through, extremes included.
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(SAMPLE_MIN, SAMPLE_MAX);
    send_word(sample_t'(0), sample_t'(-1));
    send_word(sample_t'(1), sample_t'(0));

    // A gain of one half puts odd samples exactly on halves, which round upward.
    wait_drained();
    load_coefs(COEF_HALF, '0, '0, '0, '0);
    send_word(sample_t'(1), sample_t'(-1));
    send_word(sample_t'(3), sample_t'(-3));
    send_word(sample_t'(2), sample_t'(-2));
    send_word(SAMPLE_MAX, SAMPLE_MIN);

    // Largest coefficients drive both channels into saturation.
    wait_drained();
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(SAMPLE_MIN, SAMPLE_MAX);
    send_word(sample_t'(0), sample_t'(0));

    // Most negative coefficients.
    wait_drained();
    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_word(SAMPLE_MIN, SAMPLE_MAX);
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(sample_t'(1), sample_t'(-1));
    send_word(sample_t'(0), sample_t'(0));

    // Delayed input plus unit feedback: a running sum that climbs into the rail.
    wait_drained();
    load_coefs('0, COEF_ONE, '0, -COEF_ONE, '0);
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(SAMPLE_MAX, SAMPLE_MIN);
    send_word(sample_t'(5), sample_t'(-5));
    send_word(sample_t'(0), sample_t'(0));

    // Random phases, each under a fresh coefficient set.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      load_random_coefs(phase % 3);
      calm = (phase == 4);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (phase == 6 && n == WORDS_PER_PHASE / 2) begin
          wait_drained();
        end
        send_word(pick_sample(), pick_sample());
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
